/* hdl/crc32c_block_checksum_verify_unit_macros.svh */
// ------------------------------------------------------------------------
// CRC32C checksum verify unit - assertion macros
// Concurrent assertion wrappers clocked on clock; empty for synthesis.
// ------------------------------------------------------------------------
`ifndef CRC32C_BLOCK_CHECKSUM_VERIFY_UNIT_MACROS_SVH
`define CRC32C_BLOCK_CHECKSUM_VERIFY_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// checked outside reset
`define CRCV_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked at every edge, reset included
`define CRCV_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`else

`define CRCV_ASSERT(lbl, prop, msg)
`define CRCV_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* hdl/crcv_pkg.sv */
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// crcv_pkg
// Types, constants and the byte-wise CRC32C step for the verify unit.
// ------------------------------------------------------------------------
package crcv_pkg;

   // frame and CRC constants
   localparam int          MAX_FRAME_BYTES = 4096;
   localparam int          POS_W           = 13;
   localparam int          LIMIT_W         = $clog2(MAX_FRAME_BYTES + 1) > POS_W ?
                                             $clog2(MAX_FRAME_BYTES + 1) : POS_W;
   localparam logic [POS_W-1:0]   POS_MAX  = {POS_W{1'b1}};
   localparam logic [LIMIT_W-1:0] LIMIT_MAX = LIMIT_W'(MAX_FRAME_BYTES);
   localparam logic [31:0] CRC_INIT        = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY        = 32'h82F6_3B78;
   localparam logic [7:0]  BYTE_MASK       = 8'hFF;

   // configuration registers
   localparam int          OFFSET_W        = 12;
   localparam int          LEN_LIMIT_W     = 13;
   localparam logic [LEN_LIMIT_W-1:0] LEN_LIMIT_RESET = 13'd4096;
   localparam int          CSR_ADDR_W      = 3;

   // register indexes, from paddr[2]
   localparam logic        REG_FIELD_OFFSET = 1'b0;
   localparam logic        REG_LENGTH_LIMIT = 1'b1;

   // operation codes
   localparam logic        OP_PLAIN  = 1'b0;
   localparam logic        OP_VERIFY = 1'b1;

   // status codes
   localparam logic        STATUS_OK      = 1'b0;
   localparam logic        STATUS_CORRUPT = 1'b1;

   // front to back queue
   localparam int          QUEUE_DEPTH = 2;
   localparam int          QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int          QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [OFFSET_W-1:0]    field_offset;
      logic [LEN_LIMIT_W-1:0] length_limit;
   } crcv_cfg_type;

   // one classified byte on its way to the CRC engine
   typedef struct packed {
      logic        verify;
      logic [7:0]  data;
      logic        last;
      logic        too_long;
      logic [31:0] expected;
   } crcv_entry_type;

   // reflected CRC32C over one byte, LSB first
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data & BYTE_MASK};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

/* hdl/crcv_req_if.sv */
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// crcv_req_if
// Input channel: one frame byte per item with its control fields.
// ------------------------------------------------------------------------
interface crcv_req_if
   import crcv_pkg::*;
();
   logic        valid;
   logic        ready;
   logic        operation;
   logic [7:0]  data_byte;
   logic        last_byte;
   logic [31:0] expected_checksum;

   modport source (output valid, operation, data_byte, last_byte, expected_checksum,
                   input ready);
   modport sink   (input valid, operation, data_byte, last_byte, expected_checksum,
                   output ready);
endinterface

/* hdl/crcv_rsp_if.sv */
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// crcv_rsp_if
// Result channel: CRC of a frame and its check status.
// ------------------------------------------------------------------------
interface crcv_rsp_if
   import crcv_pkg::*;
();
   logic        valid;
   logic        ready;
   logic [31:0] crc_value;
   logic        status;

   modport source (output valid, crc_value, status, input ready);
   modport sink   (input valid, crc_value, status, output ready);
endinterface

/* hdl/crcv_front.sv */
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// crcv_front
// Accepts frame bytes, tracks position, zeroes the checksum field in verify
// mode and tracks the too-long flag; pushes classified items to the queue.
// ------------------------------------------------------------------------
`include "crc32c_block_checksum_verify_unit_macros.svh"

module crcv_front
   import crcv_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  crcv_cfg_type   cfg,
   crcv_req_if.sink       req_ch,
   output logic           push,
   output crcv_entry_type push_entry,
   input  logic           queue_ready
);

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               too_long_ff, too_long_in;
   logic [LIMIT_W-1:0] limit_eff;
   logic [POS_W:0]     field_end;
   logic               in_field;
   logic               too_long_now;

   assign req_ch.ready = queue_ready;
   assign push         = req_ch.valid && queue_ready;

   // effective length limit and field window
   always_comb begin
      limit_eff = (LIMIT_W'(cfg.length_limit) > LIMIT_MAX) ? LIMIT_MAX
                                                           : LIMIT_W'(cfg.length_limit);
      field_end = (POS_W + 1)'(cfg.field_offset) + (POS_W + 1)'(3);
      in_field  = ((POS_W + 1)'(pos_ff) >= (POS_W + 1)'(cfg.field_offset)) &&
                  ((POS_W + 1)'(pos_ff) <= field_end);
      too_long_now = too_long_ff || (LIMIT_W'(pos_ff) >= limit_eff);
   end

   // classified item
   always_comb begin
      push_entry.verify   = req_ch.operation;
      push_entry.data     = ((req_ch.operation == OP_VERIFY) && in_field) ? 8'd0
                                                                         : req_ch.data_byte;
      push_entry.last     = req_ch.last_byte;
      push_entry.too_long = too_long_now;
      push_entry.expected = req_ch.expected_checksum;
   end

   // frame position and flag
   always_comb begin
      pos_in      = pos_ff;
      too_long_in = too_long_ff;
      if (push) begin
         if (req_ch.last_byte) begin
            pos_in      = '0;
            too_long_in = 1'b0;
         end else begin
            pos_in      = (pos_ff == POS_MAX) ? pos_ff : pos_ff + POS_W'(1);
            too_long_in = too_long_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         too_long_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         too_long_ff <= too_long_in;
      end
   end

   `CRCV_ASSERT(a_frame_restart, (push && req_ch.last_byte) |=> (pos_ff == '0 && !too_long_ff), "front did not restart after last byte")

endmodule

/* hdl/crcv_queue.sv */
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// crcv_queue
// Small register queue between front and back ends.
// ------------------------------------------------------------------------
`include "crc32c_block_checksum_verify_unit_macros.svh"

module crcv_queue
   import crcv_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  crcv_entry_type push_entry,
   output logic           push_ready,
   input  logic           pop,
   output crcv_entry_type pop_entry,
   output logic           pop_valid
);

   crcv_entry_type         slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign push_ready = (count_ff < QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + QUEUE_CNT_W'(1);
         2'b01:   count_in = count_ff - QUEUE_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `CRCV_ASSERT(a_no_overflow, push |-> push_ready, "queue push while full")
   `CRCV_ASSERT(a_no_underflow, pop |-> pop_valid, "queue pop while empty")

endmodule

/* hdl/crcv_back.sv */
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// crcv_back
// CRC engine: one byte per cycle from the queue, a last byte waiting while
// a result is held; result register on the last byte with the verify compare.
// ------------------------------------------------------------------------
`include "crc32c_block_checksum_verify_unit_macros.svh"

module crcv_back
   import crcv_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           pop_valid,
   input  crcv_entry_type pop_entry,
   output logic           pop,
   crcv_rsp_if.source     rsp_ch
);

   logic [31:0] crc_ff, crc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_crc_ff, rsp_crc_in;
   logic        rsp_status_ff, rsp_status_in;
   logic [31:0] crc_next;
   logic [31:0] crc_final;
   logic        out_free;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   // a non-last byte never needs the result register
   assign pop      = pop_valid && (!pop_entry.last || out_free);

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.crc_value = rsp_crc_ff;
   assign rsp_ch.status    = rsp_status_ff;

   // CRC step and result formation
   always_comb begin
      crc_next      = crc_byte(crc_ff, pop_entry.data);
      crc_final     = ~crc_next;
      crc_in        = crc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_crc_in    = rsp_crc_ff;
      rsp_status_in = rsp_status_ff;
      if (pop) begin
         if (pop_entry.last) begin
            crc_in        = CRC_INIT;
            rsp_valid_in  = 1'b1;
            rsp_crc_in    = crc_final;
            rsp_status_in = ((pop_entry.verify == OP_VERIFY) &&
                             (pop_entry.too_long || (crc_final != pop_entry.expected)))
                            ? STATUS_CORRUPT : STATUS_OK;
         end else begin
            crc_in = crc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_crc_ff    <= rsp_crc_in;
      rsp_status_ff <= rsp_status_in;
   end

   `CRCV_ASSERT_ALWAYS(a_crc_reset, $past(reset) |-> (crc_ff == CRC_INIT && !rsp_valid_ff), "CRC engine not cleared by reset")
   `CRCV_ASSERT(a_result_held, (rsp_valid_ff && !rsp_ch.ready) |=> (rsp_valid_ff && $stable(rsp_crc_ff)), "pending result overwritten")

endmodule

/* hdl/crc32c_block_checksum_verify_unit.sv */
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// crc32c_block_checksum_verify_unit
// Byte-serial CRC32C checksum and verify unit with an APB-style CSR port.
// ------------------------------------------------------------------------
// The unit takes one frame byte per item and sustains one item per clock
// while the queue is not full. The front end classifies each byte (frame
// position, checksum field zeroing in verify mode, length limit), a
// two-entry queue decouples it from the CRC engine, and the engine folds
// one byte per cycle into the register, a last byte waiting while a result
// is held. The byte marked last yields one result via the queue in the result
// register: the inverted CRC32C and, for verify, a corrupt status on a
// mismatch or an over-long frame. Input is stalled only while the queue is
// full, which happens when a result is held waiting and another last byte
// reaches the engine. Registers: 0x0 checksum field offset (12 bits),
// 0x4 length limit (13 bits, reset 4096); write them while idle.
// ------------------------------------------------------------------------
module crc32c_block_checksum_verify_unit
   import crcv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   crcv_req_if.sink              req_ch,
   crcv_rsp_if.source            rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [OFFSET_W-1:0]    field_offset_ff, field_offset_in;
   logic [LEN_LIMIT_W-1:0] length_limit_ff, length_limit_in;
   logic                   csr_write;
   crcv_cfg_type           cfg;
   logic                   push, push_ready, pop, pop_valid;
   crcv_entry_type         push_entry, pop_entry;

   // CSR write and read decode
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      field_offset_in = field_offset_ff;
      length_limit_in = length_limit_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_FIELD_OFFSET: field_offset_in = csr_pwdata[OFFSET_W-1:0];
            REG_LENGTH_LIMIT: length_limit_in = csr_pwdata[LEN_LIMIT_W-1:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_FIELD_OFFSET: csr_prdata = 32'(field_offset_ff);
         REG_LENGTH_LIMIT: csr_prdata = 32'(length_limit_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_offset_ff <= '0;
         length_limit_ff <= LEN_LIMIT_RESET;
      end else begin
         field_offset_ff <= field_offset_in;
         length_limit_ff <= length_limit_in;
      end
   end

   assign cfg.field_offset = field_offset_ff;
   assign cfg.length_limit = length_limit_ff;

   // front end
   crcv_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_ch      (req_ch),
      .push        (push),
      .push_entry  (push_entry),
      .queue_ready (push_ready)
   );

   // decoupling queue
   crcv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .pop_valid  (pop_valid)
   );

   // CRC engine
   crcv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp_ch    (rsp_ch)
   );

endmodule

/* sim/crc32c_frame_verifier.sv */
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// crc32c_frame_verifier
// Watches the byte, result and CSR ports of the CRC32C verify unit. It
// keeps its own copy of the frame state and the two registers, folds
// every accepted byte into a predicted CRC, and checks each result and
// each register read against that prediction.
// ------------------------------------------------------------------------

package crc32c_tb_pkg;
   import crcv_pkg::*;

   // predicted result of one frame
   typedef struct packed {
      logic [31:0] crc;
      logic        status;
   } frame_verdict_type;

   // reflected Castagnoli update, one data bit per step, LSB first
   function automatic logic [31:0] castagnoli_fold(input logic [31:0] acc,
                                                   input logic [7:0]  octet);
      logic [31:0] r;
      r = acc;
      for (int i = 0; i < 8; i++) begin
         if (r[0] ^ octet[i]) r = (r >> 1) ^ CRC_POLY;
         else r = r >> 1;
      end
      return r;
   endfunction
endpackage

module crc32c_frame_verifier
   import crcv_pkg::*;
   import crc32c_tb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   crcv_req_if                   req_mon,
   crcv_rsp_if                   rsp_mon,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   input  logic [31:0]           csr_prdata,
   input  logic                  csr_pready,
   output int unsigned           mismatches,
   output int unsigned           pending_results,
   output int unsigned           frames_checked,
   output int unsigned           corrupt_frames
);

   // predicted frame state and register copies
   logic [31:0]            crc_acc;
   logic [POS_W-1:0]       byte_pos;
   logic                   over_limit;
   logic [OFFSET_W-1:0]    field_offset;
   logic [LEN_LIMIT_W-1:0] length_limit;
   frame_verdict_type      verdict_q[$];

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at %0t: %s expected %08h got %08h", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin : watch
      frame_verdict_type want;
      logic [31:0]       readback;
      logic [7:0]        octet;
      int                eff_limit;
      int                pos;
      int                first;

      if (reset) begin
         crc_acc         = CRC_INIT;
         byte_pos        = '0;
         over_limit      = 1'b0;
         field_offset    = '0;
         length_limit    = LEN_LIMIT_RESET;
         verdict_q.delete();
         mismatches      = 0;
         pending_results = 0;
         frames_checked  = 0;
         corrupt_frames  = 0;
      end else begin
         // register writes and read-back
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr[2])
                  REG_FIELD_OFFSET: field_offset = csr_pwdata[OFFSET_W-1:0];
                  REG_LENGTH_LIMIT: length_limit = csr_pwdata[LEN_LIMIT_W-1:0];
               endcase
            end else begin
               case (csr_paddr[2])
                  REG_FIELD_OFFSET: readback = 32'(field_offset);
                  default:          readback = 32'(length_limit);
               endcase
               if (csr_prdata !== readback)
                  note_mismatch("register read-back", readback, csr_prdata);
            end
         end

         // result side: oldest prediction first
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (verdict_q.size() == 0) begin
               note_mismatch("result with no frame pending, crc", 32'd0, rsp_mon.crc_value);
            end else begin
               want = verdict_q.pop_front();
               frames_checked++;
               if (want.status == STATUS_CORRUPT) corrupt_frames++;
               if (rsp_mon.crc_value !== want.crc)
                  note_mismatch("crc_value", want.crc, rsp_mon.crc_value);
               if (rsp_mon.status !== want.status)
                  note_mismatch("status", 32'(want.status), 32'(rsp_mon.status));
            end
         end

         // byte side: fold the item into the running frame
         if (req_mon.valid && req_mon.ready) begin
            eff_limit = (int'(length_limit) > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES
                                                               : int'(length_limit);
            pos   = int'(byte_pos);
            first = int'(field_offset);
            octet = req_mon.data_byte;
            // checksum field reads as zero when verifying
            if (req_mon.operation == OP_VERIFY && pos >= first && pos <= first + 3)
               octet = 8'h00;
            if (pos >= eff_limit) over_limit = 1'b1;
            crc_acc = castagnoli_fold(crc_acc, octet);
            if (byte_pos != POS_MAX) byte_pos = byte_pos + POS_W'(1);

            if (req_mon.last_byte) begin
               want.crc    = ~crc_acc;
               want.status = (req_mon.operation == OP_VERIFY &&
                              (over_limit || want.crc != req_mon.expected_checksum))
                             ? STATUS_CORRUPT : STATUS_OK;
               verdict_q.push_back(want);
               crc_acc    = CRC_INIT;
               byte_pos   = '0;
               over_limit = 1'b0;
            end
         end

         pending_results = verdict_q.size();
      end
   end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the CRC32C checksum verify unit. Drives short
// directed frames, then random frames over several register settings and
// idle/stall mixes, including limits above the frame maximum and a field
// offset at the top of its range. A separate verifier predicts and checks.
// ------------------------------------------------------------------------
module testbench;
   import crcv_pkg::*;
   import crc32c_tb_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int PHASE_BYTES     = 125;
   localparam int NUM_PHASES      = 8;
   localparam int DRAIN_CYCLES    = 8;
   localparam int RESET_CYCLES    = 8;
   localparam logic [CSR_ADDR_W-1:0] ADDR_FIELD_OFFSET = {REG_FIELD_OFFSET, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_LENGTH_LIMIT = {REG_LENGTH_LIMIT, 2'b00};

   typedef enum int {MIX_PLAIN, MIX_VERIFY, MIX_BOTH} frame_mode_type;

   typedef struct packed {
      logic        op;
      logic [7:0]  data;
      logic        last;
      logic [31:0] expected;
   } frame_byte_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   crcv_req_if req_ch();
   crcv_rsp_if rsp_ch();

   int unsigned mismatches;
   int unsigned pending_results;
   int unsigned frames_checked;
   int unsigned corrupt_frames;

   int unsigned sender_idle_pct;
   int unsigned receiver_stall_pct;
   int unsigned cycle_count;
   int unsigned bytes_sent;
   logic [OFFSET_W-1:0] cur_offset;

   // register settings per random phase; -1 picks a random value
   int phase_offset [NUM_PHASES] = '{0, 5, 4095, 12, 1, -1, 2, -1};
   int phase_limit  [NUM_PHASES] = '{4096, 20, 0, 1, 8191, -1, 4097, -1};

   crc32c_block_checksum_verify_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   crc32c_frame_verifier frame_verifier (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .mismatches      (mismatches),
      .pending_results (pending_results),
      .frames_checked  (frames_checked),
      .corrupt_frames  (corrupt_frames)
   );

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("testbench: errors");
         $finish;
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // one APB transfer: setup, access, then release; starts and ends at a falling edge
   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [31:0] wdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // both registers, with junk in the unused upper bits, then read back
   task automatic set_config(input int off, input int lim);
      logic [31:0] word;
      word = $urandom();
      word[OFFSET_W-1:0] = off[OFFSET_W-1:0];
      csr_access(1'b1, ADDR_FIELD_OFFSET, word);
      word = $urandom();
      word[LEN_LIMIT_W-1:0] = lim[LEN_LIMIT_W-1:0];
      csr_access(1'b1, ADDR_LENGTH_LIMIT, word);
      csr_access(1'b0, ADDR_FIELD_OFFSET, 32'd0);
      csr_access(1'b0, ADDR_LENGTH_LIMIT, 32'd0);
      cur_offset = off[OFFSET_W-1:0];
   endtask

   // offer one byte item, with random sender gaps; called at a falling edge
   task automatic push_byte(input frame_byte_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid             <= 1'b1;
      req_ch.operation         <= item.op;
      req_ch.data_byte         <= item.data;
      req_ch.last_byte         <= item.last;
      req_ch.expected_checksum <= item.expected;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   // stream one frame; the stored checksum matches unless bad is set
   task automatic run_frame(input int len, input frame_mode_type mode, input bit bad,
                            input int fill);
      frame_byte_type item;
      logic [31:0] run;
      logic [7:0]  folded;
      run = CRC_INIT;
      for (int k = 0; k < len; k++) begin
         case (mode)
            MIX_PLAIN:  item.op = OP_PLAIN;
            MIX_VERIFY: item.op = OP_VERIFY;
            default:    item.op = 1'($urandom_range(1));
         endcase
         if (fill >= 0) begin
            item.data = fill[7:0];
         end else begin
            case ($urandom_range(9))
               0:       item.data = 8'h00;
               1:       item.data = 8'hFF;
               default: item.data = 8'($urandom());
            endcase
         end
         folded = (item.op == OP_VERIFY && k >= int'(cur_offset) &&
                   k <= int'(cur_offset) + 3) ? 8'h00 : item.data;
         run = castagnoli_fold(run, folded);
         item.last     = (k == len - 1);
         item.expected = $urandom();
         if (item.last)
            item.expected = bad ? (~run ^ (32'd1 << $urandom_range(31))) : ~run;
         push_byte(item);
      end
   endtask

   // drop valid, wait out every pending result plus the pipeline tail
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (pending_results != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      int             len;
      int             pick;
      int             sent;
      int             off;
      int             lim;
      frame_mode_type mode;
      bit             bad;

      reset                    = 1'b1;
      cycle_count              = 0;
      bytes_sent               = 0;
      sender_idle_pct          = 0;
      receiver_stall_pct       = 0;
      cur_offset               = '0;
      csr_psel                 = 1'b0;
      csr_penable              = 1'b0;
      csr_pwrite               = 1'b0;
      csr_paddr                = '0;
      csr_pwdata               = '0;
      req_ch.valid             = 1'b0;
      req_ch.operation         = OP_PLAIN;
      req_ch.data_byte         = 8'h00;
      req_ch.last_byte         = 1'b0;
      req_ch.expected_checksum = 32'd0;
      rsp_ch.ready             = 1'b0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values of the registers
      csr_access(1'b0, ADDR_FIELD_OFFSET, 32'd0);
      csr_access(1'b0, ADDR_LENGTH_LIMIT, 32'd0);

      // directed: field at byte 2, limit of 6 bytes
      set_config(2, 6);
      push_byte('{OP_PLAIN, 8'h00, 1'b1, 32'h0000_0000});
      push_byte('{OP_PLAIN, 8'hFF, 1'b1, 32'hFFFF_FFFF});
      push_byte('{OP_VERIFY, 8'hFF, 1'b1, 32'hFFFF_FFFF});
      run_frame(6, MIX_VERIFY, 1'b0, 8'hFF);   // exactly at the limit, good checksum
      run_frame(7, MIX_VERIFY, 1'b0, 8'h00);   // one byte too long
      run_frame(4, MIX_VERIFY, 1'b0, -1);      // field runs past the end of the frame
      run_frame(5, MIX_BOTH, 1'b0, -1);        // mode changes inside the frame

      // random frames over settings and idle mixes
      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         off = (phase_offset[p] < 0) ? int'($urandom_range(30)) : phase_offset[p];
         lim = (phase_limit[p] < 0)
               ? ((p == NUM_PHASES - 1) ? int'($urandom_range(8191))
                                        : int'($urandom_range(40, 1)))
               : phase_limit[p];
         set_config(off, lim);
         case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 65; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 65; end
            default: begin sender_idle_pct = 19; receiver_stall_pct = 19; end
         endcase
         sent = 0;
         while (sent < PHASE_BYTES) begin
            pick = $urandom_range(99);
            if (pick < 70)      len = $urandom_range(12, 1);
            else if (pick < 95) len = $urandom_range(40, 13);
            else                len = $urandom_range(80, 41);
            pick = $urandom_range(99);
            if (pick < 40)      begin mode = MIX_VERIFY; bad = 1'b0; end
            else if (pick < 60) begin mode = MIX_VERIFY; bad = 1'b1; end
            else if (pick < 75) begin mode = MIX_BOTH;   bad = 1'($urandom_range(1)); end
            else                begin mode = MIX_PLAIN;  bad = 1'b0; end
            run_frame(len, mode, bad, -1);
            sent += len;
         end
      end
      settle();

      $display("summary: %0d frames checked, %0d flagged corrupt, %0d bytes driven",
               frames_checked, corrupt_frames, bytes_sent);
      $display("summary: directed edge frames, then %0d random phases over settings and idle mixes",
               NUM_PHASES);
      if (mismatches == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/crcv_pkg.sv
hdl/crcv_req_if.sv
hdl/crcv_rsp_if.sv
hdl/crcv_front.sv
hdl/crcv_queue.sv
hdl/crcv_back.sv
hdl/crc32c_block_checksum_verify_unit.sv
sim/crc32c_frame_verifier.sv
sim/testbench.sv
